FILE: rtl/core/ors_pkg.sv
// Package for the 1-Wire ROM search block: sizes, input mode and result kind
// codes, and the result record passed from the engine to the result queue.
// No dependencies.
package ors_pkg;

    localparam int CODE_BITS   = 64;
    localparam int FAMILY_BITS = 8;
    localparam int ROM_W       = 64;
    localparam int POS_W       = $clog2(CODE_BITS + 1);
    localparam int IDX_W       = $clog2(CODE_BITS);

    localparam logic [1:0] MODE_RESTART = 2'd0;
    localparam logic [1:0] MODE_BEGIN   = 2'd1;
    localparam logic [1:0] MODE_BITS    = 2'd2;

    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_DIR  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [7:0] CMD_NORMAL = 8'hF0;
    localparam logic [7:0] CMD_ALARM  = 8'hEC;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       command_byte;
        logic             direction_bit;
        logic             found;
        logic [ROM_W-1:0] rom_code;
        logic             last_device;
        logic             run_last;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

FILE: rtl/core/onewire_rom_search.sv
// 1-Wire ROM search engine, top level. Depends on ors_pkg, ors_engine, ors_fifo.
// Path: an item's results are formed from the engine's input register, written into
// the result queue, and the queue head drives the outputs.
// Throughput: one input item per cycle while o_stall is low; results leave one per
// cycle while i_stall is low, from an eight-entry result queue, whose fill level alone drives o_stall.
// Reset: synchronous, active low; clears search state, pass state and the queue.
module onewire_rom_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic        i_presence,
    input  logic        i_normal_search,
    input  logic        i_id_bit,
    input  logic        i_complement_bit,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_command_byte,
    output logic        o_direction_bit,
    output logic        o_found,
    output logic [63:0] o_rom_code,
    output logic        o_last_device,
    output logic        o_run_last
);

    ors_pkg::t_push   push;
    ors_pkg::t_result head;
    logic             full;
    logic             take;

    assign o_stall = full;
    assign take    = i_valid && !full;

    ors_engine u_engine (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_take           (take),
        .i_mode           (i_mode),
        .i_presence       (i_presence),
        .i_normal_search  (i_normal_search),
        .i_id_bit         (i_id_bit),
        .i_complement_bit (i_complement_bit),
        .o_push           (push)
    );

    ors_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_full  (full),
        .o_head  (head)
    );

    assign o_kind          = head.kind;
    assign o_command_byte  = head.command_byte;
    assign o_direction_bit = head.direction_bit;
    assign o_found         = head.found;
    assign o_rom_code      = head.rom_code;
    assign o_last_device   = head.last_device;
    assign o_run_last      = head.run_last;

endmodule

FILE: rtl/core/ors_engine.sv
// Search engine: input register, search state and the per-item step logic.
// Produces up to two result records per item. Depends on ors_pkg.
module ors_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [1:0]    i_mode,
    input  logic          i_presence,
    input  logic          i_normal_search,
    input  logic          i_id_bit,
    input  logic          i_complement_bit,
    output ors_pkg::t_push o_push
);

    logic                          r_in_valid;
    logic [1:0]                    r_mode;
    logic                          r_presence;
    logic                          r_normal;
    logic                          r_id;
    logic                          r_cmp;

    logic [ors_pkg::CODE_BITS-1:0] r_rom, n_rom;
    logic [ors_pkg::POS_W-1:0]     r_pos, n_pos;
    logic [ors_pkg::POS_W-1:0]     r_zero_pos, n_zero_pos;
    logic [ors_pkg::POS_W-1:0]     r_prior, n_prior;
    logic                          r_done, n_done;
    logic                          r_active, n_active;

    logic [ors_pkg::POS_W-1:0]     pos_m1;
    logic [ors_pkg::IDX_W-1:0]     idx;
    logic                          dir;
    logic [ors_pkg::POS_W-1:0]     lz_new;
    logic                          done_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_take;
        end
        if (i_take) begin
            r_mode     <= i_mode;
            r_presence <= i_presence;
            r_normal   <= i_normal_search;
            r_id       <= i_id_bit;
            r_cmp      <= i_complement_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom      <= '0;
            r_pos      <= ors_pkg::POS_W'(1);
            r_zero_pos <= '0;
            r_prior    <= '0;
            r_done     <= 1'b0;
            r_active   <= 1'b0;
        end else begin
            r_rom      <= n_rom;
            r_pos      <= n_pos;
            r_zero_pos <= n_zero_pos;
            r_prior    <= n_prior;
            r_done     <= n_done;
            r_active   <= n_active;
        end
    end

    assign pos_m1 = r_pos - 1'b1;
    assign idx    = pos_m1[ors_pkg::IDX_W-1:0];

    always_comb begin
        // no conflict: follow the bus; conflict: replay, take 1 at the old
        // discrepancy, take 0 past it
        if (r_id != r_cmp) begin
            dir = r_id;
        end else if (r_pos < r_prior) begin
            dir = r_rom[idx];
        end else begin
            dir = (r_pos == r_prior);
        end
        lz_new = (r_id == r_cmp && !dir) ? r_pos : r_zero_pos;
    end

    assign done_new = r_done | (lz_new == '0);

    always_comb begin
        n_rom      = r_rom;
        n_pos      = r_pos;
        n_zero_pos = r_zero_pos;
        n_prior    = r_prior;
        n_done     = r_done;
        n_active   = r_active;
        o_push     = '0;

        if (r_in_valid) begin
            case (r_mode)
                ors_pkg::MODE_RESTART: begin
                    n_prior    = '0;
                    n_done     = 1'b0;
                    n_active   = 1'b0;
                    n_pos      = ors_pkg::POS_W'(1);
                    n_zero_pos = '0;
                end
                ors_pkg::MODE_BEGIN: begin
                    n_active   = 1'b0;
                    n_pos      = ors_pkg::POS_W'(1);
                    n_zero_pos = '0;
                    o_push.v0  = 1'b1;
                    o_push.r0.run_last = 1'b1;
                    if (r_done || !r_presence) begin
                        n_prior               = '0;
                        n_done                = 1'b0;
                        o_push.r0.kind        = ors_pkg::KIND_DONE;
                        o_push.r0.last_device = 1'b1;
                    end else begin
                        n_active               = 1'b1;
                        o_push.r0.kind         = ors_pkg::KIND_CMD;
                        o_push.r0.command_byte = r_normal ? ors_pkg::CMD_NORMAL
                                                          : ors_pkg::CMD_ALARM;
                    end
                end
                ors_pkg::MODE_BITS: begin
                    if (r_active) begin
                        o_push.v0 = 1'b1;
                        if (r_id && r_cmp) begin
                            n_prior               = '0;
                            n_done                = 1'b0;
                            n_active              = 1'b0;
                            n_pos                 = ors_pkg::POS_W'(1);
                            o_push.r0.kind        = ors_pkg::KIND_DONE;
                            o_push.r0.last_device = 1'b1;
                            o_push.r0.run_last    = 1'b1;
                        end else begin
                            n_rom[idx]              = dir;
                            n_zero_pos              = lz_new;
                            n_pos                   = r_pos + 1'b1;
                            o_push.r0.kind          = ors_pkg::KIND_DIR;
                            o_push.r0.direction_bit = dir;
                            if (r_pos == ors_pkg::POS_W'(ors_pkg::CODE_BITS)) begin
                                n_active           = 1'b0;
                                n_pos              = ors_pkg::POS_W'(1);
                                o_push.v1          = 1'b1;
                                o_push.r1.kind     = ors_pkg::KIND_DONE;
                                o_push.r1.run_last = 1'b1;
                                if (n_rom[ors_pkg::FAMILY_BITS-1:0] != '0) begin
                                    n_prior               = lz_new;
                                    n_done                = done_new;
                                    o_push.r1.found       = 1'b1;
                                    o_push.r1.rom_code    = ors_pkg::ROM_W'(n_rom);
                                    o_push.r1.last_device = done_new;
                                end else begin
                                    // empty family byte: not a device
                                    n_prior               = '0;
                                    n_done                = 1'b0;
                                    o_push.r1.last_device = 1'b1;
                                end
                            end else begin
                                o_push.r0.run_last = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/ors_fifo.sv
// Result queue: takes up to two result records per cycle, hands out one.
// Stall toward the input side leaves room for two items in flight. Depends on ors_pkg.
module ors_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ors_pkg::t_push  i_push,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_full,
    output ors_pkg::t_result o_head
);

    ors_pkg::t_result r_mem [ors_pkg::FIFO_DEPTH];

    logic [ors_pkg::FIFO_AW-1:0] r_head, n_head;
    logic [ors_pkg::FIFO_AW-1:0] r_tail, n_tail;
    logic [ors_pkg::FIFO_CW-1:0] r_count, n_count;
    logic [ors_pkg::FIFO_AW-1:0] tail_p1;
    logic [1:0]                  push_n;
    logic                        pop_ok;

    assign tail_p1 = r_tail + 1'b1;
    assign push_n  = {1'b0, i_push.v0} + {1'b0, i_push.v1};
    assign pop_ok  = i_pop && (r_count != '0);

    always_comb begin
        n_head  = r_head + ors_pkg::FIFO_AW'(pop_ok);
        n_tail  = r_tail + ors_pkg::FIFO_AW'(push_n);
        n_count = r_count + ors_pkg::FIFO_CW'(push_n) - ors_pkg::FIFO_CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_tail] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[tail_p1] <= i_push.r1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_head];
    // one item in the input register and one new transfer may add four entries
    assign o_full  = (r_count > ors_pkg::FIFO_CW'(ors_pkg::FIFO_DEPTH - 4));

endmodule

FILE: rtl/core/ors_checker.sv
// Port-level checks for the ROM search top level, attached by bind.
// Depends on ors_pkg.
module ors_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic        o_found,
    input logic [63:0] o_rom_code,
    input logic        o_run_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == ors_pkg::KIND_CMD || o_kind == ors_pkg::KIND_DONE)
        |-> o_run_last)
        else $error("command or finish result not marked last");

    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_kind == ors_pkg::KIND_DONE
                               && o_rom_code[ors_pkg::FAMILY_BITS-1:0] != '0)
        else $error("found set on a bad result");

endmodule

bind onewire_rom_search ors_checker u_ors_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_kind     (o_kind),
    .o_found    (o_found),
    .o_rom_code (o_rom_code),
    .o_run_last (o_run_last)
);

FILE: tb/onewire_rom_search_tb.sv
// Self-checking testbench for onewire_rom_search: directed corner cases, then enumerations
// of randomly built device sets plus stray items, then random items, with random gaps and stalls.
// Depends on ors_pkg and the onewire_rom_search RTL.
module onewire_rom_search_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode = MODE_UNUSED;
    logic        i_presence = 1'b0;
    logic        i_normal_search = 1'b0;
    logic        i_id_bit = 1'b0;
    logic        i_complement_bit = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_command_byte;
    logic        o_direction_bit;
    logic        o_found;
    logic [63:0] o_rom_code;
    logic        o_last_device;
    logic        o_run_last;

    onewire_rom_search DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_presence       (i_presence),
        .i_normal_search  (i_normal_search),
        .i_id_bit         (i_id_bit),
        .i_complement_bit (i_complement_bit),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_command_byte   (o_command_byte),
        .o_direction_bit  (o_direction_bit),
        .o_found          (o_found),
        .o_rom_code       (o_rom_code),
        .o_last_device    (o_last_device),
        .o_run_last       (o_run_last)
    );

    // search state mirror
    logic [ors_pkg::ROM_W-1:0] code_reg = '0;
    logic [ors_pkg::POS_W-1:0] bit_pos = ors_pkg::POS_W'(1);
    logic [ors_pkg::POS_W-1:0] zero_mark = '0;
    logic [ors_pkg::POS_W-1:0] prior_disc = '0;
    logic                      enum_done = 1'b0;
    logic                      in_pass = 1'b0;
    logic                      bus_dir = 1'b0;

    ors_pkg::t_result search_results_q[$];

    // simulated bus devices
    logic [63:0] dev_code[$];
    bit          dev_alarm[$];
    bit          dev_live[$];

    bit quiet = 1'b0;
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int codes_found = 0;
    int enumerations = 0;
    int cycles = 0;
    int unsigned stall_hold = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("onewire_rom_search_tb: errors");
            $finish;
        end
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] got_v);
        errors++;
        if (errors <= 40)
            $display("mismatch in %s at result %0d: expected %0h, got %0h",
                     what, results_checked, exp_v, got_v);
    endtask

    function automatic void end_pass_not_found();
        ors_pkg::t_result r;
        r = '0;
        prior_disc = '0;
        enum_done = 1'b0;
        in_pass = 1'b0;
        bit_pos = ors_pkg::POS_W'(1);
        r.kind = ors_pkg::KIND_DONE;
        r.last_device = 1'b1;
        r.run_last = 1'b1;
        search_results_q.push_back(r);
    endfunction

    function automatic void predict_search_results(input logic [1:0] mode, input logic presence,
                                                   input logic normal, input logic idb,
                                                   input logic cmpb);
        ors_pkg::t_result r;
        logic [ors_pkg::POS_W-1:0] pos;
        logic dir;
        r = '0;
        case (mode)
            ors_pkg::MODE_RESTART: begin
                prior_disc = '0;
                enum_done = 1'b0;
                in_pass = 1'b0;
                bit_pos = ors_pkg::POS_W'(1);
                zero_mark = '0;
            end
            ors_pkg::MODE_BEGIN: begin
                in_pass = 1'b0;
                bit_pos = ors_pkg::POS_W'(1);
                zero_mark = '0;
                if (enum_done || !presence) begin
                    end_pass_not_found();
                end else begin
                    in_pass = 1'b1;
                    r.kind = ors_pkg::KIND_CMD;
                    r.command_byte = normal ? ors_pkg::CMD_NORMAL : ors_pkg::CMD_ALARM;
                    r.run_last = 1'b1;
                    search_results_q.push_back(r);
                end
            end
            ors_pkg::MODE_BITS: begin
                if (in_pass) begin
                    if (idb && cmpb) begin
                        end_pass_not_found();
                    end else begin
                        pos = bit_pos;
                        if (pos < 1 || pos > ors_pkg::CODE_BITS)
                            pos = ors_pkg::POS_W'(1);
                        if (idb != cmpb) begin
                            dir = idb;
                        end else begin
                            // both branches present: follow the previous path below the
                            // last discrepancy, take 1 at it, 0 beyond it
                            if (pos < prior_disc)
                                dir = code_reg[pos - 1'b1];
                            else
                                dir = (pos == prior_disc);
                            if (!dir)
                                zero_mark = pos;
                        end
                        code_reg[pos - 1'b1] = dir;
                        bus_dir = dir;
                        r.kind = ors_pkg::KIND_DIR;
                        r.direction_bit = dir;
                        bit_pos = pos + 1'b1;
                        if (bit_pos > ors_pkg::CODE_BITS) begin
                            search_results_q.push_back(r);
                            in_pass = 1'b0;
                            bit_pos = ors_pkg::POS_W'(1);
                            prior_disc = zero_mark;
                            if (prior_disc == '0)
                                enum_done = 1'b1;
                            if (code_reg[ors_pkg::FAMILY_BITS-1:0] != '0) begin
                                r = '0;
                                r.kind = ors_pkg::KIND_DONE;
                                r.found = 1'b1;
                                r.rom_code = code_reg;
                                r.last_device = enum_done;
                                r.run_last = 1'b1;
                                search_results_q.push_back(r);
                                codes_found++;
                            end else begin
                                end_pass_not_found();
                            end
                        end else begin
                            r.run_last = 1'b1;
                            search_results_q.push_back(r);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // one input transfer; the expectation is formed once the block takes it
    task automatic send_item(input logic [1:0] mode, input logic presence, input logic normal,
                             input logic idb, input logic cmpb);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_mode <= mode;
        i_presence <= presence;
        i_normal_search <= normal;
        i_id_bit <= idb;
        i_complement_bit <= cmpb;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_search_results(mode, presence, normal, idb, cmpb);
        items_sent++;
    endtask

    // wired-AND of the devices still on the search path
    function automatic void bus_pair(input int k, output logic idb, output logic cmpb);
        idb = 1'b1;
        cmpb = 1'b1;
        foreach (dev_code[d]) begin
            if (dev_live[d]) begin
                if (dev_code[d][k])
                    cmpb = 1'b0;
                else
                    idb = 1'b0;
            end
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        ors_pkg::t_result exp_r;
        int unsigned hold_next;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_hold <= 0;
        end else begin
            hold_next = (stall_hold != 0) ? stall_hold - 1 : 0;
            if (o_valid && !i_stall) begin
                results_checked++;
                if (search_results_q.size() == 0) begin
                    report_mismatch("unexpected result, kind", '0, 64'(o_kind));
                end else begin
                    exp_r = search_results_q.pop_front();
                    if (o_kind !== exp_r.kind)
                        report_mismatch("kind", 64'(exp_r.kind), 64'(o_kind));
                    if (o_command_byte !== exp_r.command_byte)
                        report_mismatch("command_byte", 64'(exp_r.command_byte),
                                        64'(o_command_byte));
                    if (o_direction_bit !== exp_r.direction_bit)
                        report_mismatch("direction_bit", 64'(exp_r.direction_bit),
                                        64'(o_direction_bit));
                    if (o_found !== exp_r.found)
                        report_mismatch("found", 64'(exp_r.found), 64'(o_found));
                    if (o_rom_code !== exp_r.rom_code)
                        report_mismatch("rom_code", exp_r.rom_code, o_rom_code);
                    if (o_last_device !== exp_r.last_device)
                        report_mismatch("last_device", 64'(exp_r.last_device),
                                        64'(o_last_device));
                    if (o_run_last !== exp_r.run_last)
                        report_mismatch("run_last", 64'(exp_r.run_last), 64'(o_run_last));
                end
                hold_next = quiet ? 0 : $urandom_range(0, 7);
            end
            stall_hold <= hold_next;
            i_stall <= (hold_next != 0);
        end
    end

    task automatic test_directed_cases();
        send_item(ors_pkg::MODE_RESTART, 1'b1, 1'b1, 1'b1, 1'b1);
        send_item(MODE_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1);
        send_item(ors_pkg::MODE_BITS, 1'b0, 1'b0, 1'b0, 1'b1);   // no pass open: dropped
        send_item(ors_pkg::MODE_BEGIN, 1'b0, 1'b1, 1'b0, 1'b0);  // no presence
        send_item(ors_pkg::MODE_BEGIN, 1'b1, 1'b0, 1'b1, 1'b1);  // alarm search
        send_item(ors_pkg::MODE_BITS, 1'b1, 1'b1, 1'b1, 1'b0);
        send_item(ors_pkg::MODE_BITS, 1'b0, 1'b0, 1'b0, 1'b1);
        send_item(ors_pkg::MODE_BITS, 1'b0, 1'b1, 1'b0, 1'b0);   // discrepancy
        send_item(ors_pkg::MODE_BITS, 1'b0, 1'b0, 1'b1, 1'b1);   // no device answered: abort
        send_item(ors_pkg::MODE_BITS, 1'b1, 1'b0, 1'b0, 1'b0);   // dropped after abort
        send_item(ors_pkg::MODE_BEGIN, 1'b1, 1'b1, 1'b0, 1'b0);
        send_item(ors_pkg::MODE_BITS, 1'b1, 1'b1, 1'b0, 1'b0);
        send_item(ors_pkg::MODE_BEGIN, 1'b1, 1'b1, 1'b1, 1'b0);  // restarts the open pass
        send_item(ors_pkg::MODE_BITS, 1'b0, 1'b0, 1'b1, 1'b0);
        send_item(MODE_UNUSED, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ors_pkg::MODE_BITS, 1'b1, 1'b0, 1'b0, 1'b1);
        send_item(ors_pkg::MODE_RESTART, 1'b0, 1'b0, 1'b0, 1'b0);
        send_item(ors_pkg::MODE_BITS, 1'b1, 1'b1, 1'b1, 1'b1);   // dropped after restart
    endtask

    // full enumeration of a random device set, sometimes broken off by a stray item or an abort
    task automatic run_enumeration();
        int ndev;
        int idx;
        logic [63:0] c;
        logic [1:0] stray;
        logic normal, idb, cmpb, pres, any;
        ndev = $urandom_range(1, 5);
        dev_code.delete();
        dev_alarm.delete();
        dev_live.delete();
        for (int d = 0; d < ndev; d++) begin
            c = {$urandom, $urandom};
            case ($urandom_range(0, 7))
                0: c[7:0] = 8'h00;
                1: c = '1;
                2, 3: begin
                    // near neighbor forces deep discrepancies
                    if (d > 0) begin
                        c = dev_code[$urandom_range(0, d - 1)];
                        idx = $urandom_range(0, 63);
                        c[idx] = ~c[idx];
                    end
                end
                default: ;
            endcase
            dev_code.push_back(c);
            dev_alarm.push_back(coin());
            dev_live.push_back(1'b0);
        end
        enumerations++;
        send_item(ors_pkg::MODE_RESTART, coin(), coin(), coin(), coin());
        normal = ($urandom_range(0, 3) != 0);
        for (int p = 0; p < ndev + 2; p++) begin
            any = 1'b0;
            foreach (dev_code[d]) begin
                dev_live[d] = normal || dev_alarm[d];
                any |= dev_live[d];
            end
            pres = any ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 3) == 0);
            send_item(ors_pkg::MODE_BEGIN, pres, normal, coin(), coin());
            if (!in_pass)
                return;
            for (int k = 0; k < ors_pkg::CODE_BITS; k++) begin
                if ($urandom_range(0, 299) == 0) begin
                    stray = 2'($urandom_range(0, 2));
                    if (stray == ors_pkg::MODE_BITS)
                        stray = MODE_UNUSED;
                    send_item(stray, coin(), coin(), coin(), coin());
                    return;
                end
                bus_pair(k, idb, cmpb);
                send_item(ors_pkg::MODE_BITS, coin(), coin(), idb, cmpb);
                if (idb && cmpb)
                    return;
                foreach (dev_code[d])
                    if (dev_live[d] && dev_code[d][k] != bus_dir)
                        dev_live[d] = 1'b0;
            end
            if (enum_done) begin
                // one more begin once the last device is known
                send_item(ors_pkg::MODE_BEGIN, 1'b1, normal, coin(), coin());
                return;
            end
        end
    endtask

    task automatic test_enumerations();
        while (items_sent < 1100) begin
            quiet = ($urandom_range(0, 3) == 0);
            run_enumeration();
        end
        quiet = 1'b0;
    endtask

    task automatic test_random_items();
        for (int n = 0; n < 150; n++)
            send_item(2'($urandom_range(0, 3)), coin(), coin(), coin(), coin());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_enumerations();
        test_random_items();
        i_valid <= 1'b0;
        while (search_results_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d items sent over %0d enumerations, %0d results checked, %0d codes found",
                 items_sent, enumerations, results_checked, codes_found);
        if (errors == 0)
            $display("onewire_rom_search_tb: clean");
        else
            $display("onewire_rom_search_tb: errors");
        $finish;
    end

endmodule
